// ===== rtl/k_way_sorted_run_merge_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the k-way merge
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_RUN_MERGE_TOP_MACROS_SVH
`define K_WAY_SORTED_RUN_MERGE_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define KWM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define KWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define KWM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// k-way merge package
// Widths, register indexes, transaction types and the lane count clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int unsigned MAX_LANES = 8;
  localparam int unsigned LANE_W    = $clog2(MAX_LANES);
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SELECT = 1'd1;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    logic              last;
  } kwm_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
    logic [LANE_W-1:0] src;
    logic              done;
  } kwm_result_t;

  function automatic logic [CNT_W-1:0] lanes_active(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (n < CNT_W'(2)) begin
      n = CNT_W'(2);
    end else if (n > CNT_W'(MAX_LANES)) begin
      n = CNT_W'(MAX_LANES);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kwm_front.sv =====
// ----------------------------------------------------------------------------
// k-way merge front end
// Accepts input transactions, drops those for inactive lanes and queues the
// rest in a two-entry buffer toward the merge engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_front
  import kwm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [LANE_W-1:0]  lane_i,
  input  wire logic [WORD_W-1:0]  in_left_i,
  input  wire logic [WORD_W-1:0]  in_right_i,
  input  wire logic               lane_final_i,
  input  wire logic [CNT_W-1:0]   lane_count_i,
  output logic                    item_valid_o,
  output kwm_item_t               item_o,
  input  wire logic               item_pop_i
);

  kwm_item_t  buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       lane_live;
  logic       wr_en;
  logic       rd_en;

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_ptr_q];

  assign accept    = push & ~full;
  assign lane_live = (CNT_W'(lane_i) < lanes_active(lane_count_i));
  assign wr_en     = accept & lane_live;
  assign rd_en     = item_pop_i & item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_ptr_q] <= '{lane: lane_i, left: in_left_i, right: in_right_i,
                           last: lane_final_i};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwm_res_fifo.sv =====
// ----------------------------------------------------------------------------
// k-way merge result queue
// Two-entry queue that holds emitted pairs until the consumer pops them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kwm_res_fifo
  import kwm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  res_push_i,
  input  kwm_result_t res_i,
  output logic       res_full_o,
  output logic       empty,
  input  wire logic  pop,
  output kwm_result_t res_o
);

  kwm_result_t buf_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_en;
  logic        rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign res_o      = buf_q[rd_ptr_q];

  assign wr_en = res_push_i & ~res_full_o;
  assign rd_en = pop & ~empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kwm_back.sv =====
// ----------------------------------------------------------------------------
// k-way merge engine
// Holds the lane heads, loads one queued transaction, then emits the
// smallest head once per cycle while every active lane is ready and the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "k_way_sorted_run_merge_top_macros.svh"

module kwm_back
  import kwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CNT_W-1:0]  lane_count_i,
  input  wire logic              key_select_i,
  input  wire logic              item_valid_i,
  input  kwm_item_t              item_i,
  output logic                   item_pop_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output kwm_result_t            res_o
);

  localparam int unsigned LVLS = LANE_W;
  localparam int unsigned PAD  = 1 << LANE_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                 state_q, state_d;
  logic [MAX_LANES-1:0] head_valid_q, head_valid_d;
  logic [MAX_LANES-1:0] head_final_q, head_final_d;
  logic [MAX_LANES-1:0] lane_done_q, lane_done_d;
  logic [WORD_W-1:0]    head_left_q  [MAX_LANES];
  logic [WORD_W-1:0]    head_right_q [MAX_LANES];

  logic [CNT_W-1:0]     n_act;
  logic [MAX_LANES-1:0] mask;
  logic                 all_ready;
  logic                 lv_ok  [0:LVLS][0:PAD-1];
  logic [WORD_W-1:0]    lv_key [0:LVLS][0:PAD-1];
  logic [LANE_W-1:0]    lv_idx [0:LVLS][0:PAD-1];
  logic                 sel_any;
  logic [LANE_W-1:0]    best;
  logic                 head_we;
  logic                 res_done;

  assign n_act = lanes_active(lane_count_i);

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      mask[i] = (CNT_W'(i) < n_act);
    end
  end

  assign all_ready = &(head_valid_q | lane_done_q | ~mask);

  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int j = 0; j < PAD; j++) begin
        lv_ok[l][j]  = 1'b0;
        lv_key[l][j] = '0;
        lv_idx[l][j] = '0;
      end
    end
    for (int i = 0; i < MAX_LANES; i++) begin
      lv_ok[0][i]  = head_valid_q[i] & mask[i];
      lv_key[0][i] = key_select_i ? head_right_q[i] : head_left_q[i];
      lv_idx[0][i] = LANE_W'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < (PAD >> (l + 1)); j++) begin
        if (lv_ok[l][2*j+1] &&
            (!lv_ok[l][2*j] || (lv_key[l][2*j+1] < lv_key[l][2*j]))) begin
          lv_ok[l+1][j]  = 1'b1;
          lv_key[l+1][j] = lv_key[l][2*j+1];
          lv_idx[l+1][j] = lv_idx[l][2*j+1];
        end else begin
          lv_ok[l+1][j]  = lv_ok[l][2*j];
          lv_key[l+1][j] = lv_key[l][2*j];
          lv_idx[l+1][j] = lv_idx[l][2*j];
        end
      end
    end
  end

  assign sel_any = lv_ok[LVLS][0];
  assign best    = lv_idx[LVLS][0];

  assign head_we = (state_q == ST_IDLE) && item_valid_i && !lane_done_q[item_i.lane];

  always_comb begin
    state_d      = state_q;
    head_valid_d = head_valid_q;
    head_final_d = head_final_q;
    lane_done_d  = lane_done_q;
    item_pop_o   = 1'b0;
    res_push_o   = 1'b0;
    res_done     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (!lane_done_q[item_i.lane]) begin
            head_valid_d[item_i.lane] = 1'b1;
            head_final_d[item_i.lane] = item_i.last;
            state_d                   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!(all_ready && sel_any)) begin
          state_d = ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o         = 1'b1;
          head_valid_d[best] = 1'b0;
          if (head_final_q[best]) begin
            head_final_d[best] = 1'b0;
            lane_done_d[best]  = 1'b1;
          end
          res_done = &(lane_done_d | ~mask);
          if (res_done) begin
            head_valid_d = '0;
            head_final_d = '0;
            lane_done_d  = '0;
            state_d      = ST_IDLE;
          end
        end
      end
    endcase
  end

  assign res_o = '{left: head_left_q[best], right: head_right_q[best], src: best,
                   done: res_done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_valid_q <= '0;
      head_final_q <= '0;
      lane_done_q  <= '0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      head_final_q <= head_final_d;
      lane_done_q  <= lane_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_left_q[item_i.lane]  <= item_i.left;
      head_right_q[item_i.lane] <= item_i.right;
    end
  end

  `KWM_ASSERT_IMP(a_push_in_emit, res_push_o, state_q == ST_EMIT, "result pushed outside emit")
  `KWM_ASSERT_NXT(a_done_clears, res_push_o && res_done, (head_valid_q == '0) && (lane_done_q == '0), "merge state not cleared after final pair")
  `KWM_ASSERT_ALWAYS(a_valid_not_done, (head_valid_q & lane_done_q) == '0, "finished lane holds a valid head")
  `KWM_ASSERT_ALWAYS(a_final_needs_valid, (head_final_q & ~head_valid_q) == '0, "final flag without valid head")

endmodule

`default_nettype wire

// ===== rtl/k_way_sorted_run_merge_top.sv =====
// ----------------------------------------------------------------------------
// k-way sorted run merge, top level
// Merges up to eight sorted runs of 32-bit pairs into one sorted stream.
//
//   Channel   Handshake        Payload
//   input     push / full      lane_i, in_left_i, in_right_i, lane_final_i
//   result    empty / pop      out_left_o, out_right_o, source_lane_o, merge_done_o
//   config    cfg_we_i         cfg_idx_i, cfg_data_i
//
// Inactive-lane transactions are dropped on acceptance; a finished-lane one
// is popped and dropped by the engine. Otherwise the engine loads the head,
// emits one pair per cycle while all active lanes are ready and the result
// queue has room, and goes idle when no pair is ready or the merge closes.
// Two-entry input and result queues decouple the sides; a full result queue
// holds the engine in place. Reset clears all lane state, two lanes, left key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_run_merge_top
  import kwm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [LANE_W-1:0]    lane_i,
  input  wire logic [WORD_W-1:0]    in_left_i,
  input  wire logic [WORD_W-1:0]    in_right_i,
  input  wire logic                 lane_final_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [WORD_W-1:0]         out_left_o,
  output logic [WORD_W-1:0]         out_right_o,
  output logic [LANE_W-1:0]         source_lane_o,
  output logic                      merge_done_o
);

  logic [CNT_W-1:0] lane_count_q, lane_count_d;
  logic             key_select_q, key_select_d;
  logic             item_valid;
  kwm_item_t        item;
  logic             item_pop;
  logic             res_full;
  logic             res_push;
  kwm_result_t      res_in;
  kwm_result_t      res_out;

  always_comb begin
    lane_count_d = lane_count_q;
    key_select_d = key_select_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LANE_COUNT: lane_count_d = cfg_data_i[CNT_W-1:0];
        REG_KEY_SELECT: key_select_d = cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= CNT_W'(2);
      key_select_q <= 1'b0;
    end else begin
      lane_count_q <= lane_count_d;
      key_select_q <= key_select_d;
    end
  end

  kwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .lane_i       (lane_i),
    .in_left_i    (in_left_i),
    .in_right_i   (in_right_i),
    .lane_final_i (lane_final_i),
    .lane_count_i (lane_count_q),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  kwm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lane_count_i (lane_count_q),
    .key_select_i (key_select_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  kwm_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign out_left_o    = res_out.left;
  assign out_right_o   = res_out.right;
  assign source_lane_o = res_out.src;
  assign merge_done_o  = res_out.done;

endmodule

`default_nettype wire
